>>> design/nnsw_pkg.sv
// Shared types and constants for the nearest-neighbor scale writer.
// Holds the register file layout, the descriptor passed from front to back
// and the queue sizing. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nnsw_pkg;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SCALE_X    = 3'd2;
  localparam logic [2:0] REG_SCALE_Y    = 3'd3;
  localparam logic [2:0] REG_DST_PITCH  = 3'd4;
  localparam logic [2:0] REG_BPP        = 3'd5;

  localparam int ADDR_W = 5;

  localparam logic [15:0] RST_SRC_WIDTH  = 16'd640;
  localparam logic [15:0] RST_SRC_HEIGHT = 16'd480;
  localparam logic [19:0] RST_SCALE      = 20'd65536;
  localparam logic [17:0] RST_DST_PITCH  = 18'd2560;
  localparam logic [2:0]  RST_BPP        = 3'd4;

  // Descriptor queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam int POS_W = 36;

  typedef struct packed {
    logic [15:0] src_width;
    logic [15:0] src_height;
    logic [19:0] scale_x;
    logic [19:0] scale_y;
    logic [17:0] dst_pitch;
    logic [2:0]  bpp;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic [15:0] base_x;
    logic [15:0] base_y;
    logic        frame_end;
  } desc_t;

endpackage

`default_nettype wire

>>> design/nnsw_front.sv
// Front end: accepts source pixels, tracks raster position and running
// fixed-point destination positions, and pushes one descriptor per pixel.
// Depends on nnsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nnsw_front import nnsw_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic [31:0] in_pixel_value,
  input  wire logic  q_ready,
  output logic       q_push,
  output desc_t      q_desc
);

  logic [15:0]      src_col_r, src_col_nxt;
  logic [15:0]      src_row_r, src_row_nxt;
  logic [POS_W-1:0] col_pos_r, col_pos_nxt;
  logic [POS_W-1:0] row_pos_r, row_pos_nxt;
  logic [POS_W-1:0] col_shift, row_shift;
  logic             end_col, end_row;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  assign col_shift = col_pos_r >> FRAC_BITS;
  assign row_shift = row_pos_r >> FRAC_BITS;

  // A zero size or a counter past the size ends the row or frame at once
  assign end_col = ({1'b0, src_col_r} + 17'd1) >= {1'b0, cfg.src_width};
  assign end_row = ({1'b0, src_row_r} + 17'd1) >= {1'b0, cfg.src_height};

  always_comb begin
    q_desc.pixel     = in_pixel_value;
    q_desc.base_x    = col_shift[15:0];
    q_desc.base_y    = row_shift[15:0];
    q_desc.frame_end = end_col && end_row;
  end

  always_comb begin
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (q_push) begin
      if (end_col) begin
        src_col_nxt = '0;
        col_pos_nxt = '0;
        if (end_row) begin
          src_row_nxt = '0;
          row_pos_nxt = '0;
        end else begin
          src_row_nxt = src_row_r + 16'd1;
          row_pos_nxt = row_pos_r + POS_W'(cfg.scale_y);
        end
      end else begin
        src_col_nxt = src_col_r + 16'd1;
        col_pos_nxt = col_pos_r + POS_W'(cfg.scale_x);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/nnsw_fifo.sv
// Short descriptor queue between the front and back ends.
// Ready depends only on fill level, so each side stalls on its own.
// Depends on nnsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nnsw_fifo import nnsw_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t push_desc,
  output logic       push_ready,
  input  wire logic  pop,
  output logic       pop_valid,
  output desc_t      pop_desc
);

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign push_ready = count_r != QCNT_W'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_desc   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

>>> design/nnsw_back.sv
// Back end: expands each descriptor into a block of destination writes,
// computes byte addresses in a two-stage multiply/add pipeline and holds
// the result in an output register. Depends on nnsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nnsw_back import nnsw_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_REPEAT = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  q_valid,
  input  wire desc_t q_desc,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [15:0] out_dst_col,
  output logic [15:0] out_dst_row,
  output logic [33:0] out_byte_addr,
  output logic [31:0] out_pixel_value,
  output logic [3:0]  out_byte_mask,
  output logic        out_last_of_run,
  output logic        out_last_of_frame
);

  localparam int IDX_W = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;
  localparam int SUM_W = 26;
  localparam logic [SUM_W-1:0] ROUND_UP = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [SUM_W-1:0] MAX_CNT  = SUM_W'(MAX_REPEAT);

  function automatic logic [IDX_W-1:0] last_index(input logic [19:0] scale);
    logic [SUM_W-1:0] ceil_cnt;
    logic [SUM_W-1:0] idx;
    ceil_cnt = ({6'b0, scale} + ROUND_UP) >> FRAC_BITS;
    if (ceil_cnt == '0) begin
      idx = '0;
    end else if (ceil_cnt > MAX_CNT) begin
      idx = MAX_CNT - 1'b1;
    end else begin
      idx = ceil_cnt - 1'b1;
    end
    return idx[IDX_W-1:0];
  endfunction

  // Settings from configuration; the user keeps cfg stable while items are in flight (not enforced)
  logic [IDX_W-1:0] nx_last_r, ny_last_r;
  logic [2:0]       bpp_r;
  logic [3:0]       mask_r;

  always_ff @(posedge clk) begin
    nx_last_r <= last_index(cfg.scale_x);
    ny_last_r <= last_index(cfg.scale_y);
    case (cfg.bpp)
      3'd0, 3'd1: begin
        bpp_r  <= 3'd1;
        mask_r <= 4'b0001;
      end
      3'd2: begin
        bpp_r  <= 3'd2;
        mask_r <= 4'b0011;
      end
      3'd3: begin
        bpp_r  <= 3'd3;
        mask_r <= 4'b0111;
      end
      default: begin
        bpp_r  <= 3'd4;
        mask_r <= 4'b1111;
      end
    endcase
  end

  // Whole pipe advances together when the output register can move
  logic adv;
  assign adv = !out_valid || out_ready;

  // Block walker
  logic             cur_valid_r;
  desc_t            cur_r;
  logic [IDX_W-1:0] ox_r, oy_r;
  logic             x_end, y_end, cur_last, fire;

  assign x_end    = ox_r == nx_last_r;
  assign y_end    = oy_r == ny_last_r;
  assign cur_last = x_end && y_end;
  assign fire     = cur_valid_r && adv;
  assign q_pop    = q_valid && (!cur_valid_r || (fire && cur_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      ox_r        <= '0;
      oy_r        <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      ox_r        <= '0;
      oy_r        <= '0;
    end else if (fire) begin
      if (cur_last) begin
        cur_valid_r <= 1'b0;
      end else if (x_end) begin
        ox_r <= '0;
        oy_r <= oy_r + 1'b1;
      end else begin
        ox_r <= ox_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_desc;
    end
  end

  // Stage 1: destination coordinates
  logic        s1_valid_r;
  logic [15:0] s1_dx_r, s1_dy_r;
  logic [31:0] s1_pixel_r;
  logic        s1_run_r, s1_frame_r;

  // Stage 2: partial address products
  logic        s2_valid_r;
  logic [15:0] s2_dx_r, s2_dy_r;
  logic [31:0] s2_pixel_r;
  logic        s2_run_r, s2_frame_r;
  logic [33:0] s2_row_off_r;
  logic [17:0] s2_col_off_r;

  // Output register
  logic        out_valid_r;
  logic [15:0] out_dx_r, out_dy_r;
  logic [33:0] out_addr_r;
  logic [31:0] out_pixel_r;
  logic        out_run_r, out_frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= cur_valid_r;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r    <= cur_r.base_x + 16'(ox_r);
      s1_dy_r    <= cur_r.base_y + 16'(oy_r);
      s1_pixel_r <= cur_r.pixel;
      s1_run_r   <= cur_last;
      s1_frame_r <= cur_last && cur_r.frame_end;

      s2_dx_r      <= s1_dx_r;
      s2_dy_r      <= s1_dy_r;
      s2_pixel_r   <= s1_pixel_r;
      s2_run_r     <= s1_run_r;
      s2_frame_r   <= s1_frame_r;
      s2_row_off_r <= {18'b0, s1_dy_r} * {16'b0, cfg.dst_pitch};
      s2_col_off_r <= {2'b0, s1_dx_r} * {15'b0, bpp_r};

      out_dx_r    <= s2_dx_r;
      out_dy_r    <= s2_dy_r;
      out_addr_r  <= s2_row_off_r + {16'b0, s2_col_off_r};
      out_pixel_r <= s2_pixel_r;
      out_run_r   <= s2_run_r;
      out_frame_r <= s2_frame_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_dst_col       = out_dx_r;
  assign out_dst_row       = out_dy_r;
  assign out_byte_addr     = out_addr_r;
  assign out_pixel_value   = out_pixel_r;
  assign out_byte_mask     = mask_r;
  assign out_last_of_run   = out_run_r;
  assign out_last_of_frame = out_frame_r;

endmodule

`default_nettype wire

>>> design/nearest_neighbor_scale_writer_top.sv
// Nearest-neighbor upscaler write generator, top level.
// Holds the APB register file and ties front, queue and back together.
// Depends on nnsw_pkg, nnsw_front, nnsw_fifo, nnsw_back.
//
// Usage:
//   Source pixels enter in raster order on in_valid/in_ready/in_pixel_value.
//   Each pixel becomes a block of ny rows by nx columns of destination
//   writes on out_*, with nx = ceil(scale_x) and ny = ceil(scale_y), each
//   clamped to 1..MAX_REPEAT; last_of_run marks the final write of a pixel.
//   Registers are to be written through the APB port only while the block
//   is idle; the block itself does not enforce it. The back-end walker
//   issues nx*ny writes per pixel, one write per cycle unless out_ready
//   holds the pipe; at unit scale one pixel per cycle. A pixel passes the
//   queue, walker, coordinate, multiply and add stages before its first write.
//   While out_valid is high and out_ready low the back end holds; the
//   two-entry descriptor queue keeps accepting pixels until it fills, then
//   in_ready drops. Reset (rst_n low, synchronous) restores the register
//   defaults (640x480, unit scale, pitch 2560, 4 bytes per pixel), zeroes
//   the raster position and empties the queue and pipeline.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_scale_writer_top import nnsw_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_REPEAT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [31:0]       in_pixel_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [15:0]            out_dst_col,
  output logic [15:0]            out_dst_row,
  output logic [33:0]            out_byte_addr,
  output logic [31:0]            out_pixel_out,
  output logic [3:0]             out_byte_mask,
  output logic                   out_last_of_run,
  output logic                   out_last_of_frame
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width  <= RST_SRC_WIDTH;
      cfg_r.src_height <= RST_SRC_HEIGHT;
      cfg_r.scale_x    <= RST_SCALE;
      cfg_r.scale_y    <= RST_SCALE;
      cfg_r.dst_pitch  <= RST_DST_PITCH;
      cfg_r.bpp        <= RST_BPP;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SRC_WIDTH:  cfg_r.src_width  <= pwdata[15:0];
        REG_SRC_HEIGHT: cfg_r.src_height <= pwdata[15:0];
        REG_SCALE_X:    cfg_r.scale_x    <= pwdata[19:0];
        REG_SCALE_Y:    cfg_r.scale_y    <= pwdata[19:0];
        REG_DST_PITCH:  cfg_r.dst_pitch  <= pwdata[17:0];
        REG_BPP:        cfg_r.bpp        <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_WIDTH:  prdata = {16'b0, cfg_r.src_width};
      REG_SRC_HEIGHT: prdata = {16'b0, cfg_r.src_height};
      REG_SCALE_X:    prdata = {12'b0, cfg_r.scale_x};
      REG_SCALE_Y:    prdata = {12'b0, cfg_r.scale_y};
      REG_DST_PITCH:  prdata = {14'b0, cfg_r.dst_pitch};
      REG_BPP:        prdata = {29'b0, cfg_r.bpp};
      default:        prdata = '0;
    endcase
  end

  logic  q_ready, q_push, q_valid, q_pop;
  desc_t push_desc, pop_desc;

  nnsw_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_value (in_pixel_value),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_desc         (push_desc)
  );

  nnsw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (push_desc),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_desc   (pop_desc)
  );

  nnsw_back #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_REPEAT (MAX_REPEAT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_desc            (pop_desc),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_dst_col       (out_dst_col),
    .out_dst_row       (out_dst_row),
    .out_byte_addr     (out_byte_addr),
    .out_pixel_value   (out_pixel_out),
    .out_byte_mask     (out_byte_mask),
    .out_last_of_run   (out_last_of_run),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

`default_nettype wire
